[rtl/rxg_pkg.sv]
// ----------------------------------------------------------------------------
// rxg_pkg
// Shared types, codes and constant tables of the RGB/XYZ gamma converter.
// ----------------------------------------------------------------------------
package rxg_pkg;

    // fraction bits produced by the log2 squaring chain
    localparam int LOG_BITS   = 24;
    // fraction bits of the gamma exponents
    localparam int GAMMA_FRAC = 12;
    // width of the exponent registers
    localparam int EXP_W      = 16;
    // mantissa width of log2 and exp2 datapaths
    localparam int MANT_W     = 32;
    // register index width
    localparam int CFG_IDX_W  = 3;

    // conversion selector
    typedef enum logic [1:0] {
        FUNC_RGB2XYZ_GAMMA = 2'd0,
        FUNC_XYZ2RGB_GAMMA = 2'd1,
        FUNC_RGB2XYZ_LIN   = 2'd2,
        FUNC_XYZ2RGB_LIN   = 2'd3
    } t_func;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_RED   = 3'd0,
        CFG_FWD_GREEN = 3'd1,
        CFG_FWD_BLUE  = 3'd2,
        CFG_INV_X     = 3'd3,
        CFG_INV_Y     = 3'd4,
        CFG_INV_Z     = 3'd5,
        CFG_GAMMA     = 3'd6,
        CFG_INV_GAMMA = 3'd7
    } t_cfg_idx;

    // control that travels with every transaction
    typedef struct packed {
        t_func func;
        logic  clip;
    } t_ctl;

    // integer square root, bit pair at a time
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int n = 0; n < 32; n++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // exp2 table: entry k is 2^(2^-k) in Q1.31, each the root of the one before
    function automatic logic [MANT_W-1:0] exp_rom(input int k);
        logic [63:0] c;
        c = 64'h0000_0001_0000_0000;
        for (int j = 1; j <= LOG_BITS; j++) begin
            if (j <= k) begin
                c = isqrt64(c << 31);
            end
        end
        return c[MANT_W-1:0];
    endfunction

endpackage

[rtl/rxg_in_if.sv]
// ----------------------------------------------------------------------------
// rxg_in_if
// Input color channel: selector, three components and alpha.
// ----------------------------------------------------------------------------
interface rxg_in_if #(
    parameter int COMP_WIDTH = 25
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COMP_WIDTH-1:0] in_c0;
    logic signed [COMP_WIDTH-1:0] in_c1;
    logic signed [COMP_WIDTH-1:0] in_c2;
    logic signed [COMP_WIDTH-1:0] alpha_in;

    modport source (output valid, func, in_c0, in_c1, in_c2, alpha_in, input ready);
    modport sink   (input valid, func, in_c0, in_c1, in_c2, alpha_in, output ready);
endinterface

[rtl/rxg_out_if.sv]
// ----------------------------------------------------------------------------
// rxg_out_if
// Result color channel: three components, alpha and the saturation flag.
// ----------------------------------------------------------------------------
interface rxg_out_if #(
    parameter int COMP_WIDTH = 25
);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] out_c0;
    logic signed [COMP_WIDTH-1:0] out_c1;
    logic signed [COMP_WIDTH-1:0] out_c2;
    logic signed [COMP_WIDTH-1:0] alpha_out;
    logic                         clipped;

    modport source (output valid, out_c0, out_c1, out_c2, alpha_out, clipped, input ready);
    modport sink   (input valid, out_c0, out_c1, out_c2, alpha_out, clipped, output ready);
endinterface

[rtl/rxg_pow.sv]
// ----------------------------------------------------------------------------
// rxg_pow
// Pipelined power unit x^g = exp2(g * log2 x) on three lanes. Applied only
// when the transaction selector matches, otherwise components pass unchanged.
// ----------------------------------------------------------------------------
module rxg_pow #(
    parameter int COMP_WIDTH = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rxg_pkg::t_func                   i_sel_func,
    input  logic [rxg_pkg::EXP_W-1:0]        i_exp,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  rxg_pkg::t_ctl                    i_ctl,
    input  logic signed [COMP_WIDTH-1:0]     i_alpha,
    input  logic signed [COMP_WIDTH-1:0]     i_c [3],
    output logic                             o_valid,
    input  logic                             i_ready,
    output rxg_pkg::t_ctl                    o_ctl,
    output logic signed [COMP_WIDTH-1:0]     o_alpha,
    output logic signed [COMP_WIDTH-1:0]     o_c [3]
);

    localparam int NL      = rxg_pkg::LOG_BITS;
    localparam int MW      = rxg_pkg::MANT_W;
    localparam int GF      = rxg_pkg::GAMMA_FRAC;
    localparam int CF      = COMP_WIDTH - 9;
    localparam int PW      = $clog2(COMP_WIDTH);
    localparam int SHW     = $clog2(MW);
    localparam int PCW     = 6;
    localparam int LGW     = NL + PCW;
    localparam int PRW     = LGW + rxg_pkg::EXP_W + 1;
    localparam int EW      = PRW - GF + 1;
    localparam int IPW     = EW - NL;
    localparam int NS      = 2 * NL + 4;
    localparam int ST_PROD = NL + 1;
    localparam int ST_DEC  = NL + 2;
    localparam logic signed [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};

    // common per-stage transaction data
    logic [NS:0]                  w_v;
    logic [NS:0]                  w_en;
    logic [NS:0]                  w_byp;
    rxg_pkg::t_ctl                w_ctl   [NS+1];
    logic signed [COMP_WIDTH-1:0] w_alpha [NS+1];
    logic signed [COMP_WIDTH-1:0] w_x     [NS+1][3];
    logic                         r_v     [NS];
    logic                         r_byp   [NS];
    rxg_pkg::t_ctl                r_ctl   [NS];
    rxg_pkg::t_ctl                n_ctl   [NS];
    logic signed [COMP_WIDTH-1:0] r_alpha [NS];
    logic signed [COMP_WIDTH-1:0] r_x     [NS][3];
    logic signed [COMP_WIDTH-1:0] n_x     [NS][3];
    rxg_pkg::t_ctl                n_ctl_last;

    // log2 section
    logic                         r_lz [NL+1][3];
    logic [PW-1:0]                r_lp [NL+1][3];
    logic [MW-1:0]                r_lm [NL][3];
    logic [NL-1:0]                r_lf [NL+1][3];
    // product section
    logic                         r_pz [3];
    logic signed [PRW-1:0]        r_pr [3];
    // exp2 section
    logic                         r_ez [NL+1][3];
    logic                         r_es [NL+1][3];
    logic [PW-1:0]                r_ei [NL+1][3];
    logic [NL-1:0]                r_ef [NL][3];
    logic [MW-1:0]                r_em [1:NL][3];

    assign w_v[0]     = i_valid;
    assign w_ctl[0]   = i_ctl;
    assign w_alpha[0] = i_alpha;
    assign w_x[0]     = i_c;
    assign w_byp[0]   = (i_ctl.func != i_sel_func);
    assign w_en[NS]   = i_ready;
    assign o_ready    = w_en[0];

    assign o_valid = w_v[NS];
    assign o_ctl   = w_ctl[NS];
    assign o_alpha = w_alpha[NS];
    assign o_c     = w_x[NS];

    // stage valid chain, a stage loads when empty or when its successor moves
    for (genvar s = 0; s < NS; s++) begin : g_stage
        assign w_en[s]      = ~r_v[s] | w_en[s+1];
        assign w_v[s+1]     = r_v[s];
        assign w_byp[s+1]   = r_byp[s];
        assign w_ctl[s+1]   = r_ctl[s];
        assign w_alpha[s+1] = r_alpha[s];
        assign w_x[s+1]     = r_x[s];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (w_en[s]) begin
                r_v[s] <= w_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_byp[s]   <= w_byp[s];
                r_ctl[s]   <= n_ctl[s];
                r_alpha[s] <= w_alpha[s];
                r_x[s]     <= n_x[s];
            end
        end

        if (s != NS - 1) begin : g_pass
            assign n_ctl[s] = w_ctl[s];
            assign n_x[s]   = w_x[s];
        end else begin : g_fin
            assign n_ctl[s] = n_ctl_last;
        end
    end

    // saturation of any active lane marks the transaction
    always_comb begin
        n_ctl_last      = w_ctl[NS-1];
        n_ctl_last.clip = w_ctl[NS-1].clip
                        | (~w_byp[NS-1] & (r_es[NL][0] | r_es[NL][1] | r_es[NL][2]));
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [PW-1:0]                n_p;
        logic [MW-1:0]                n_m;
        logic [PCW-1:0]               pc;
        logic signed [LGW-1:0]        lg;
        logic signed [PRW-1:0]        pr;
        logic signed [EW-1:0]         ex;
        logic signed [IPW-1:0]        ip;
        logic [SHW-1:0]               shamt;
        logic signed [COMP_WIDTH-1:0] y;

        // leading one and normalization to Q1.31
        always_comb begin
            n_p = '0;
            for (int i = 0; i < COMP_WIDTH; i++) begin
                if (i_c[k][i]) begin
                    n_p = PW'(i);
                end
            end
            n_m = MW'($unsigned(i_c[k])) << (SHW'(MW - 1) - SHW'(n_p));
        end

        always_ff @(posedge i_clk) begin
            if (w_en[0]) begin
                r_lz[0][k] <= i_c[k][COMP_WIDTH-1] | (i_c[k] == '0);
                r_lp[0][k] <= n_p;
                r_lm[0][k] <= n_m;
                r_lf[0][k] <= '0;
            end
        end

        // one fraction bit of log2 per squaring stage
        for (genvar s = 1; s <= NL; s++) begin : g_sq
            logic [2*MW-1:0] sq;
            assign sq = r_lm[s-1][k] * r_lm[s-1][k];

            always_ff @(posedge i_clk) begin
                if (w_en[s]) begin
                    r_lz[s][k] <= r_lz[s-1][k];
                    r_lp[s][k] <= r_lp[s-1][k];
                    r_lf[s][k] <= {r_lf[s-1][k][NL-2:0], sq[2*MW-1]};
                end
            end

            if (s < NL) begin : g_m
                always_ff @(posedge i_clk) begin
                    if (w_en[s]) begin
                        r_lm[s][k] <= sq[2*MW-1] ? sq[2*MW-1:MW] : sq[2*MW-2:MW-1];
                    end
                end
            end
        end

        // log2 times exponent
        assign pc = PCW'(r_lp[NL][k]) - PCW'(CF);
        assign lg = $signed({pc, r_lf[NL][k]});
        assign pr = lg * $signed({1'b0, i_exp});

        always_ff @(posedge i_clk) begin
            if (w_en[ST_PROD]) begin
                r_pz[k] <= r_lz[NL][k];
                r_pr[k] <= pr;
            end
        end

        // split into integer and fraction, flag overflow and underflow
        assign ex = EW'($signed(r_pr[k][PRW-1:GF])) + EW'(CF <<< NL);
        assign ip = ex[EW-1:NL];

        always_ff @(posedge i_clk) begin
            if (w_en[ST_DEC]) begin
                r_ez[0][k] <= r_pz[k] | ip[IPW-1];
                r_es[0][k] <= ~r_pz[k] & (ip >= $signed(IPW'(COMP_WIDTH - 1)));
                r_ei[0][k] <= ip[PW-1:0];
                r_ef[0][k] <= ex[NL-1:0];
            end
        end

        // exp2: one table factor per fraction bit
        for (genvar j = 1; j <= NL; j++) begin : g_exp
            localparam logic [MW-1:0] CJ = rxg_pkg::exp_rom(j);
            logic [MW-1:0]   m_in;
            logic [2*MW-1:0] mp;

            if (j == 1) begin : g_first
                assign m_in = MW'(1) << (MW - 1);
            end else begin : g_next
                assign m_in = r_em[j-1][k];
            end
            assign mp = m_in * CJ;

            always_ff @(posedge i_clk) begin
                if (w_en[ST_DEC+j]) begin
                    r_em[j][k] <= r_ef[j-1][k][NL-j] ? mp[2*MW-2:MW-1] : m_in;
                    r_ez[j][k] <= r_ez[j-1][k];
                    r_es[j][k] <= r_es[j-1][k];
                    r_ei[j][k] <= r_ei[j-1][k];
                end
            end

            if (j < NL) begin : g_f
                always_ff @(posedge i_clk) begin
                    if (w_en[ST_DEC+j]) begin
                        r_ef[j][k] <= r_ef[j-1][k];
                    end
                end
            end
        end

        // final scaling and result select
        assign shamt = SHW'(MW - 1) - SHW'(r_ei[NL][k]);

        always_comb begin
            priority if (w_byp[NS-1]) begin
                y = w_x[NS-1][k];
            end else if (r_es[NL][k]) begin
                y = SAT_MAX;
            end else if (r_ez[NL][k]) begin
                y = '0;
            end else begin
                y = COMP_WIDTH'(r_em[NL][k] >> shamt);
            end
        end

        assign n_x[NS-1][k] = y;
    end

    // reset empties every stage
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> (w_v[NS:1] == '0))
        else $error("pipeline not empty after reset");

    // a powered lane never yields a negative component
    a_pow_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !w_byp[NS])
        |-> !(o_c[0][COMP_WIDTH-1] | o_c[1][COMP_WIDTH-1] | o_c[2][COMP_WIDTH-1]))
        else $error("negative power result");

    // an empty pipeline always takes a transaction
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[NS:1] == '0) |-> o_ready)
        else $error("empty pipeline stalls input");

endmodule

[rtl/rxg_mat.sv]
// ----------------------------------------------------------------------------
// rxg_mat
// Three-stage 3x3 matrix multiply with round half up and saturation.
// Forward columns for RGB to XYZ, inverse columns for XYZ to RGB.
// ----------------------------------------------------------------------------
module rxg_mat #(
    parameter int COMP_WIDTH = 25,
    parameter int COEF_WIDTH = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [3*COEF_WIDTH-1:0]        i_fwd [3],
    input  logic [3*COEF_WIDTH-1:0]        i_inv [3],
    input  logic                           i_valid,
    output logic                           o_ready,
    input  rxg_pkg::t_ctl                  i_ctl,
    input  logic signed [COMP_WIDTH-1:0]   i_alpha,
    input  logic signed [COMP_WIDTH-1:0]   i_c [3],
    output logic                           o_valid,
    input  logic                           i_ready,
    output rxg_pkg::t_ctl                  o_ctl,
    output logic signed [COMP_WIDTH-1:0]   o_alpha,
    output logic signed [COMP_WIDTH-1:0]   o_c [3]
);

    localparam int KF = COEF_WIDTH - 4;
    localparam int PW = COEF_WIDTH + COMP_WIDTH;
    localparam int AW = PW + 2;
    localparam logic signed [COMP_WIDTH-1:0] SAT_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam logic signed [COMP_WIDTH-1:0] SAT_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

    logic [3:0]                   w_en;
    logic                         r_v     [3];
    rxg_pkg::t_ctl                r_ctl   [3];
    logic signed [COMP_WIDTH-1:0] r_alpha [3];
    logic                         w_fwd;
    logic [3*COEF_WIDTH-1:0]      w_col   [3];
    logic signed [PW-1:0]         n_mp    [3][3];
    logic signed [PW-1:0]         r_mp    [3][3];
    logic signed [AW-1:0]         n_acc   [3];
    logic signed [AW-1:0]         r_acc   [3];
    logic signed [AW-1:0]         w_sh    [3];
    logic [2:0]                   w_ovf;
    logic signed [COMP_WIDTH-1:0] n_c     [3];
    logic signed [COMP_WIDTH-1:0] r_c     [3];
    rxg_pkg::t_ctl                n_ctl2;

    // handshake chain
    assign w_en[3] = i_ready;
    assign w_en[2] = ~r_v[2] | w_en[3];
    assign w_en[1] = ~r_v[1] | w_en[2];
    assign w_en[0] = ~r_v[0] | w_en[1];
    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_v[1] <= r_v[0];
            end
            if (w_en[2]) begin
                r_v[2] <= r_v[1];
            end
        end
    end

    // coefficient select and the nine products
    assign w_fwd = (i_ctl.func == rxg_pkg::FUNC_RGB2XYZ_GAMMA)
                || (i_ctl.func == rxg_pkg::FUNC_RGB2XYZ_LIN);

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_col[j] = w_fwd ? i_fwd[j] : i_inv[j];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_mp[i][j] = PW'($signed(w_col[j][i*COEF_WIDTH +: COEF_WIDTH])) * PW'(i_c[j]);
            end
        end
    end

    // row sums plus rounding offset
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_acc[i] = AW'(r_mp[i][0]) + AW'(r_mp[i][1]) + AW'(r_mp[i][2])
                     + (AW'(1) <<< (KF - 1));
        end
    end

    // scale down and saturate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sh[i]  = r_acc[i] >>> KF;
            w_ovf[i] = !((&w_sh[i][AW-1:COMP_WIDTH-1]) | ~(|w_sh[i][AW-1:COMP_WIDTH-1]));
            if (w_ovf[i]) begin
                n_c[i] = w_sh[i][AW-1] ? SAT_MIN : SAT_MAX;
            end else begin
                n_c[i] = w_sh[i][COMP_WIDTH-1:0];
            end
        end
        n_ctl2      = r_ctl[1];
        n_ctl2.clip = r_ctl[1].clip | (|w_ovf);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ctl[0]   <= i_ctl;
            r_alpha[0] <= i_alpha;
            r_mp       <= n_mp;
        end
        if (w_en[1]) begin
            r_ctl[1]   <= r_ctl[0];
            r_alpha[1] <= r_alpha[0];
            r_acc      <= n_acc;
        end
        if (w_en[2]) begin
            r_ctl[2]   <= n_ctl2;
            r_alpha[2] <= r_alpha[1];
            r_c        <= n_c;
        end
    end

    assign o_valid = r_v[2];
    assign o_ctl   = r_ctl[2];
    assign o_alpha = r_alpha[2];
    assign o_c     = r_c;

endmodule

[rtl/rgb_xyz_gamma_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_xyz_gamma_converter_top
// RGB/XYZ color conversion with programmable matrices and power-law gamma.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one color per transaction (selector, three components,
//   alpha); o_out returns one converted color per transaction, with alpha
//   copied and a flag set when any component saturated.
//   Selector 0 decodes gamma then applies the forward matrix, 1 applies the
//   inverse matrix then encodes gamma, 2 and 3 are the same without gamma.
//   Users load matrices and exponents over the write port only while no
//   transaction is in flight; the block itself does not enforce this.
// Timing:
//   every transaction passes a decode power unit (52 stages), the matrix
//   (3 stages) and an encode power unit (52 stages) between acceptance and
//   a valid result. One transaction per cycle is accepted unless the output
//   stalls; the 24-step squaring and 24-step exp2 chains set the depth.
// Reset and stalls:
//   reset empties the pipeline and loads identity matrices and unit
//   exponents. A stalled receiver holds the output; bubbles inside the
//   pipeline still close up, so input is taken until every stage is full.
// ----------------------------------------------------------------------------
module rgb_xyz_gamma_converter_top #(
    parameter int COMP_WIDTH = 25,
    parameter int COEF_WIDTH = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [rxg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [3*COEF_WIDTH-1:0]           i_cfg_data,
    rxg_in_if.sink                            i_in,
    rxg_out_if.source                         o_out
);

    localparam int CW3 = 3 * COEF_WIDTH;
    localparam int KF  = COEF_WIDTH - 4;

    // configuration registers
    logic [CW3-1:0]              r_fwd [3];
    logic [CW3-1:0]              r_inv [3];
    logic [rxg_pkg::EXP_W-1:0]   r_gam;
    logic [rxg_pkg::EXP_W-1:0]   r_igam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_fwd[j] <= (CW3'(1) << KF) << (j * COEF_WIDTH);
                r_inv[j] <= (CW3'(1) << KF) << (j * COEF_WIDTH);
            end
            r_gam  <= rxg_pkg::EXP_W'(1) << rxg_pkg::GAMMA_FRAC;
            r_igam <= rxg_pkg::EXP_W'(1) << rxg_pkg::GAMMA_FRAC;
        end else if (i_cfg_wr_en) begin
            unique case (rxg_pkg::t_cfg_idx'(i_cfg_index))
                rxg_pkg::CFG_FWD_RED:   r_fwd[0] <= i_cfg_data;
                rxg_pkg::CFG_FWD_GREEN: r_fwd[1] <= i_cfg_data;
                rxg_pkg::CFG_FWD_BLUE:  r_fwd[2] <= i_cfg_data;
                rxg_pkg::CFG_INV_X:     r_inv[0] <= i_cfg_data;
                rxg_pkg::CFG_INV_Y:     r_inv[1] <= i_cfg_data;
                rxg_pkg::CFG_INV_Z:     r_inv[2] <= i_cfg_data;
                rxg_pkg::CFG_GAMMA:     r_gam    <= i_cfg_data[rxg_pkg::EXP_W-1:0];
                rxg_pkg::CFG_INV_GAMMA: r_igam   <= i_cfg_data[rxg_pkg::EXP_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction unpack
    rxg_pkg::t_ctl                in_ctl;
    logic signed [COMP_WIDTH-1:0] in_c [3];

    assign in_ctl.func = rxg_pkg::t_func'(i_in.func);
    assign in_ctl.clip = 1'b0;
    assign in_c[0]     = i_in.in_c0;
    assign in_c[1]     = i_in.in_c1;
    assign in_c[2]     = i_in.in_c2;

    // inter-unit links
    logic                         dec_valid, dec_ready;
    rxg_pkg::t_ctl                dec_ctl;
    logic signed [COMP_WIDTH-1:0] dec_alpha;
    logic signed [COMP_WIDTH-1:0] dec_c [3];
    logic                         mat_valid, mat_ready;
    rxg_pkg::t_ctl                mat_ctl;
    logic signed [COMP_WIDTH-1:0] mat_alpha;
    logic signed [COMP_WIDTH-1:0] mat_c [3];
    rxg_pkg::t_ctl                enc_ctl;
    logic signed [COMP_WIDTH-1:0] enc_c [3];

    // gamma decode ahead of the forward matrix
    rxg_pow #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sel_func (rxg_pkg::FUNC_RGB2XYZ_GAMMA),
        .i_exp      (r_gam),
        .i_valid    (i_in.valid),
        .o_ready    (i_in.ready),
        .i_ctl      (in_ctl),
        .i_alpha    (i_in.alpha_in),
        .i_c        (in_c),
        .o_valid    (dec_valid),
        .i_ready    (dec_ready),
        .o_ctl      (dec_ctl),
        .o_alpha    (dec_alpha),
        .o_c        (dec_c)
    );

    // matrix stage
    rxg_mat #(
        .COMP_WIDTH (COMP_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mat (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fwd      (r_fwd),
        .i_inv      (r_inv),
        .i_valid    (dec_valid),
        .o_ready    (dec_ready),
        .i_ctl      (dec_ctl),
        .i_alpha    (dec_alpha),
        .i_c        (dec_c),
        .o_valid    (mat_valid),
        .i_ready    (mat_ready),
        .o_ctl      (mat_ctl),
        .o_alpha    (mat_alpha),
        .o_c        (mat_c)
    );

    // gamma encode after the inverse matrix, last stage is the output register
    rxg_pow #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_enc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sel_func (rxg_pkg::FUNC_XYZ2RGB_GAMMA),
        .i_exp      (r_igam),
        .i_valid    (mat_valid),
        .o_ready    (mat_ready),
        .i_ctl      (mat_ctl),
        .i_alpha    (mat_alpha),
        .i_c        (mat_c),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_ctl      (enc_ctl),
        .o_alpha    (o_out.alpha_out),
        .o_c        (enc_c)
    );

    // result transaction pack
    assign o_out.out_c0  = enc_c[0];
    assign o_out.out_c1  = enc_c[1];
    assign o_out.out_c2  = enc_c[2];
    assign o_out.clipped = enc_ctl.clip;

endmodule
